/* hw/rtl/avr_pkg.sv */
// ============================================================================
// avr_pkg
// Shared widths, types and the quarter-wave sine table for the axis-angle
// vector rotator.
// ============================================================================
package avr_pkg;

    // Fixed-point format and table size
    localparam int FRAC_BITS       = 16;
    localparam int TRIG_INDEX_BITS = 12;
    localparam int ANGLE_W         = 16;
    localparam int VEC_W           = 32;
    localparam int AXIS_W          = 18;

    localparam int QUARTER    = 1 << (TRIG_INDEX_BITS - 2);
    localparam int ROM_ADDR_W = TRIG_INDEX_BITS - 1;
    localparam int ROM_W      = FRAC_BITS + 1;
    localparam int TRIG_W     = FRAC_BITS + 2;
    localparam int OMC_W      = FRAC_BITS + 3;
    localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

    // Datapath widths, each bounded by its operand ranges
    localparam int PROD_W  = VEC_W + AXIS_W;
    localparam int CR_W    = PROD_W + 1 - FRAC_BITS;
    localparam int DOT_W   = PROD_W + 2 - FRAC_BITS;
    localparam int NDOT_W  = AXIS_W + DOT_W;
    localparam int AXIAL_W = NDOT_W - FRAC_BITS;
    localparam int VC_W    = VEC_W + TRIG_W;
    localparam int CRS_W   = CR_W + TRIG_W;
    localparam int PART_W  = ((CRS_W > VC_W) ? CRS_W : VC_W) + 1;
    localparam int AXP_W   = AXIAL_W + OMC_W;
    localparam int ACC_W   = ((PART_W > AXP_W) ? PART_W : AXP_W) + 1;

    // Stream packing
    localparam int IN_DATA_W   = 3 * VEC_W + 3 * AXIS_W + ANGLE_W;
    localparam int IN_TDATA_W  = ((IN_DATA_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = 3 * VEC_W;
    localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

    // Q30 constants for building the sine table
    localparam logic [63:0] Q30_ONE     = 64'h0000_0000_4000_0000;
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

    typedef logic signed [VEC_W-1:0]  vec_t;
    typedef logic signed [AXIS_W-1:0] axis_t;
    typedef logic signed [TRIG_W-1:0] trig_t;
    typedef logic signed [OMC_W-1:0]  omc_t;
    typedef logic signed [CR_W-1:0]   cr_t;
    typedef logic signed [DOT_W-1:0]  dot_t;
    typedef logic [ROM_W-1:0]         rom_word_t;
    typedef rom_word_t                sine_rom_t [0:QUARTER];

    // Per-stage load enables of the six-stage pipeline
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
        logic ld5;
        logic ld6;
    } stage_ctl_t;

    // Quarter-wave sine: Q30 Horner series to x^13, rounded and capped at one
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        for (int p = 0; p <= QUARTER; p++) begin
            x  = (64'(p) * Q30_HALF_PI + 64'(QUARTER / 2)) / 64'(QUARTER);
            x2 = (x * x) >> 30;
            t  = Q30_ONE;
            t  = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
            t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
            t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
            t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
            t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
            t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
            s  = (x * t) >> 30;
            s  = (s + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
            if (s > (64'd1 << FRAC_BITS))
            begin
                s = 64'd1 << FRAC_BITS;
            end
            rom[p] = s[ROM_W-1:0];
        end
        return rom;
    endfunction

endpackage

/* hw/rtl/avr_trig.sv */
// ============================================================================
// avr_trig
// Sine, cosine and one-minus-cosine of the binary angle from a quarter-wave
// ROM: registered ROM read in stage 1, sign and complement in stage 2.
// ============================================================================
module avr_trig (
    input  logic                          clk,
    input  avr_pkg::stage_ctl_t           ctl,
    input  logic [avr_pkg::ANGLE_W-1:0]   angle,
    output avr_pkg::trig_t                sn,
    output avr_pkg::trig_t                cs,
    output avr_pkg::omc_t                 omc
);

    localparam int IDX_W = avr_pkg::TRIG_INDEX_BITS;
    localparam int POS_W = IDX_W - 2;

    localparam avr_pkg::sine_rom_t SINE_ROM = avr_pkg::build_sine_rom();
    localparam avr_pkg::omc_t      TRIG_ONE = avr_pkg::OMC_W'(1 << avr_pkg::FRAC_BITS);

    logic [IDX_W-1:0]                sin_idx;
    logic [IDX_W-1:0]                cos_idx;
    logic [avr_pkg::ROM_ADDR_W-1:0]  sin_addr;
    logic [avr_pkg::ROM_ADDR_W-1:0]  cos_addr;

    avr_pkg::rom_word_t sin_mag_reg;
    avr_pkg::rom_word_t cos_mag_reg;
    logic               sin_neg_reg;
    logic               cos_neg_reg;

    avr_pkg::trig_t sn_next;
    avr_pkg::trig_t cs_next;
    avr_pkg::omc_t  omc_next;
    avr_pkg::trig_t sn_reg;
    avr_pkg::trig_t cs_reg;
    avr_pkg::omc_t  omc_reg;

    // Truncate the angle to a table index; cosine leads by a quarter turn
    assign sin_idx = angle[avr_pkg::ANGLE_W-1 -: IDX_W];
    assign cos_idx = sin_idx + IDX_W'(avr_pkg::QUARTER);

    // Mirror the position in odd quadrants
    always_comb
    begin
        if (sin_idx[IDX_W-2])
        begin
            sin_addr = avr_pkg::ROM_ADDR_W'(avr_pkg::QUARTER) - {1'b0, sin_idx[POS_W-1:0]};
        end
        else
        begin
            sin_addr = {1'b0, sin_idx[POS_W-1:0]};
        end
        if (cos_idx[IDX_W-2])
        begin
            cos_addr = avr_pkg::ROM_ADDR_W'(avr_pkg::QUARTER) - {1'b0, cos_idx[POS_W-1:0]};
        end
        else
        begin
            cos_addr = {1'b0, cos_idx[POS_W-1:0]};
        end
    end

    // Stage 1: registered ROM read at both addresses
    always_ff @(posedge clk)
    begin
        if (ctl.ld1)
        begin
            sin_mag_reg <= SINE_ROM[sin_addr];
            cos_mag_reg <= SINE_ROM[cos_addr];
            sin_neg_reg <= sin_idx[IDX_W-1];
            cos_neg_reg <= cos_idx[IDX_W-1];
        end
    end

    // Negate in the lower half turn, form one minus cosine
    always_comb
    begin
        sn_next  = sin_neg_reg ? -$signed({1'b0, sin_mag_reg}) : $signed({1'b0, sin_mag_reg});
        cs_next  = cos_neg_reg ? -$signed({1'b0, cos_mag_reg}) : $signed({1'b0, cos_mag_reg});
        omc_next = TRIG_ONE - avr_pkg::OMC_W'(cs_next);
    end

    // Stage 2
    always_ff @(posedge clk)
    begin
        if (ctl.ld2)
        begin
            sn_reg  <= sn_next;
            cs_reg  <= cs_next;
            omc_reg <= omc_next;
        end
    end

    assign sn  = sn_reg;
    assign cs  = cs_reg;
    assign omc = omc_reg;

endmodule

/* hw/rtl/avr_front.sv */
// ============================================================================
// avr_front
// Axis-by-vector products in stage 1, then the rounded cross product and
// dot product in stage 2. Vector and axis travel alongside.
// ============================================================================
module avr_front (
    input  logic                 clk,
    input  avr_pkg::stage_ctl_t  ctl,
    input  avr_pkg::vec_t        vec      [3],
    input  avr_pkg::axis_t       axis     [3],
    output avr_pkg::vec_t        vec_out  [3],
    output avr_pkg::axis_t       axis_out [3],
    output avr_pkg::cr_t         cr       [3],
    output avr_pkg::dot_t        dot
);

    localparam int DIFF_W = avr_pkg::PROD_W + 1;
    localparam int SUM_W  = avr_pkg::PROD_W + 2;

    logic signed [avr_pkg::PROD_W-1:0] nv_reg [3][3];
    avr_pkg::vec_t  vec_s1_reg  [3];
    avr_pkg::axis_t axis_s1_reg [3];
    avr_pkg::vec_t  vec_s2_reg  [3];
    avr_pkg::axis_t axis_s2_reg [3];

    logic signed [DIFF_W-1:0] cr_sum  [3];
    logic signed [SUM_W-1:0]  dot_sum;
    avr_pkg::cr_t             cr_next [3];
    avr_pkg::dot_t            dot_next;
    avr_pkg::cr_t             cr_reg  [3];
    avr_pkg::dot_t            dot_reg;

    // Stage 1: every axis component times every vector component
    always_ff @(posedge clk)
    begin
        if (ctl.ld1)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    nv_reg[i][j] <= axis[i] * vec[j];
                end
                vec_s1_reg[i]  <= vec[i];
                axis_s1_reg[i] <= axis[i];
            end
        end
    end

    // Cross and dot sums with the rounding half folded in
    always_comb
    begin
        cr_sum[0] = DIFF_W'(nv_reg[1][2]) - DIFF_W'(nv_reg[2][1])
                  + DIFF_W'(avr_pkg::ROUND_HALF);
        cr_sum[1] = DIFF_W'(nv_reg[2][0]) - DIFF_W'(nv_reg[0][2])
                  + DIFF_W'(avr_pkg::ROUND_HALF);
        cr_sum[2] = DIFF_W'(nv_reg[0][1]) - DIFF_W'(nv_reg[1][0])
                  + DIFF_W'(avr_pkg::ROUND_HALF);
        dot_sum   = SUM_W'(nv_reg[0][0]) + SUM_W'(nv_reg[1][1]) + SUM_W'(nv_reg[2][2])
                  + SUM_W'(avr_pkg::ROUND_HALF);
        for (int i = 0; i < 3; i++)
        begin
            cr_next[i] = avr_pkg::CR_W'(cr_sum[i] >>> avr_pkg::FRAC_BITS);
        end
        dot_next = avr_pkg::DOT_W'(dot_sum >>> avr_pkg::FRAC_BITS);
    end

    // Stage 2
    always_ff @(posedge clk)
    begin
        if (ctl.ld2)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cr_reg[i]      <= cr_next[i];
                vec_s2_reg[i]  <= vec_s1_reg[i];
                axis_s2_reg[i] <= axis_s1_reg[i];
            end
            dot_reg <= dot_next;
        end
    end

    assign vec_out  = vec_s2_reg;
    assign axis_out = axis_s2_reg;
    assign cr       = cr_reg;
    assign dot      = dot_reg;

endmodule

/* hw/rtl/avr_lane.sv */
// ============================================================================
// avr_lane
// One output component, stages 3 to 6: the three Rodrigues terms, their
// sum, rounding and saturation into the output register.
// ============================================================================
module avr_lane (
    input  logic                 clk,
    input  avr_pkg::stage_ctl_t  ctl,
    input  avr_pkg::vec_t        vec,
    input  avr_pkg::axis_t       axis,
    input  avr_pkg::cr_t         cr,
    input  avr_pkg::dot_t        dot,
    input  avr_pkg::trig_t       sn,
    input  avr_pkg::trig_t       cs,
    input  avr_pkg::omc_t        omc,
    output avr_pkg::vec_t        rot
);

    localparam int NDOT_W  = avr_pkg::NDOT_W;
    localparam int AXIAL_W = avr_pkg::AXIAL_W;
    localparam int PART_W  = avr_pkg::PART_W;
    localparam int AXP_W   = avr_pkg::AXP_W;
    localparam int ACC_W   = avr_pkg::ACC_W;
    localparam int VEC_W   = avr_pkg::VEC_W;

    logic signed [NDOT_W-1:0]       nd_reg;
    logic signed [avr_pkg::VC_W-1:0]  vc_reg;
    logic signed [avr_pkg::CRS_W-1:0] crs_reg;
    avr_pkg::omc_t                  omc_s3_reg;

    logic signed [NDOT_W-1:0]  nd_rnd;
    logic signed [AXIAL_W-1:0] axial_next;
    logic signed [PART_W-1:0]  part_next;
    logic signed [AXIAL_W-1:0] axial_reg;
    logic signed [PART_W-1:0]  part_s4_reg;
    avr_pkg::omc_t             omc_s4_reg;

    logic signed [AXP_W-1:0]   axp_reg;
    logic signed [PART_W-1:0]  part_s5_reg;

    logic signed [ACC_W-1:0]   acc_sum;
    logic signed [ACC_W-1:0]   acc_rnd;
    logic                      acc_fits;
    avr_pkg::vec_t             rot_next;
    avr_pkg::vec_t             rot_reg;

    // Stage 3: axial projection, cosine term and sine term products
    always_ff @(posedge clk)
    begin
        if (ctl.ld3)
        begin
            nd_reg     <= axis * dot;
            vc_reg     <= vec * cs;
            crs_reg    <= cr * sn;
            omc_s3_reg <= omc;
        end
    end

    // Round the axial component, add the first two terms
    always_comb
    begin
        nd_rnd     = (nd_reg + NDOT_W'(avr_pkg::ROUND_HALF)) >>> avr_pkg::FRAC_BITS;
        axial_next = AXIAL_W'(nd_rnd);
        part_next  = PART_W'(vc_reg) + PART_W'(crs_reg);
    end

    // Stage 4
    always_ff @(posedge clk)
    begin
        if (ctl.ld4)
        begin
            axial_reg   <= axial_next;
            part_s4_reg <= part_next;
            omc_s4_reg  <= omc_s3_reg;
        end
    end

    // Stage 5: axial term times one minus cosine
    always_ff @(posedge clk)
    begin
        if (ctl.ld5)
        begin
            axp_reg     <= axial_reg * omc_s4_reg;
            part_s5_reg <= part_s4_reg;
        end
    end

    // Sum, round half up, clamp to the 32-bit range
    always_comb
    begin
        acc_sum  = ACC_W'(part_s5_reg) + ACC_W'(axp_reg) + ACC_W'(avr_pkg::ROUND_HALF);
        acc_rnd  = acc_sum >>> avr_pkg::FRAC_BITS;
        acc_fits = (&acc_rnd[ACC_W-1:VEC_W-1]) || !(|acc_rnd[ACC_W-1:VEC_W-1]);
        if (acc_fits)
        begin
            rot_next = acc_rnd[VEC_W-1:0];
        end
        else
        begin
            rot_next = {acc_rnd[ACC_W-1], {(VEC_W-1){~acc_rnd[ACC_W-1]}}};
        end
    end

    // Stage 6: output register
    always_ff @(posedge clk)
    begin
        if (ctl.ld6)
        begin
            rot_reg <= rot_next;
        end
    end

    assign rot = rot_reg;

endmodule

/* hw/rtl/axis_angle_vector_rotate.sv */
// ============================================================================
// axis_angle_vector_rotate
// Rotates a Q15.16 vector about a unit axis by a binary angle with the
// Rodrigues formula, six pipeline stages, one beat per cycle when unstalled.
// ============================================================================
//
// Channel   Dir  Beat contents (lowest bits first)
// s_axis    in   vec_x, vec_y, vec_z (32b), axis_x, axis_y, axis_z (18b), angle (16b)
// m_axis    out  rot_x, rot_y, rot_z (32b, saturated)
//
// Throughput is one beat per cycle while m_axis_tready is high; the six
// registered stages (ROM read and products, cross/dot rounding, term
// products, axial rounding, axial product, sum) lie between the input
// accept and the output. Reset clears only the stage valid bits. Each stage
// holds while the next is full and stalled, so bubbles close up and
// s_axis_tready stays high unless all six stages hold beats and m_axis_tready is low.
//
module axis_angle_vector_rotate (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle, zero pad
    input  logic [avr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // rot_x, rot_y, rot_z
    output logic [avr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int NUM_STAGES = 6;
    localparam int VEC_W      = avr_pkg::VEC_W;
    localparam int AXIS_W     = avr_pkg::AXIS_W;
    localparam int AXIS_OFS   = 3 * VEC_W;
    localparam int ANGLE_OFS  = AXIS_OFS + 3 * AXIS_W;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] ld;
    avr_pkg::stage_ctl_t   ctl;

    avr_pkg::vec_t                 vec       [3];
    avr_pkg::axis_t                axis      [3];
    logic [avr_pkg::ANGLE_W-1:0]   angle;
    avr_pkg::vec_t                 vec_s2    [3];
    avr_pkg::axis_t                axis_s2   [3];
    avr_pkg::cr_t                  cr        [3];
    avr_pkg::dot_t                 dot;
    avr_pkg::trig_t                sn;
    avr_pkg::trig_t                cs;
    avr_pkg::omc_t                 omc;
    avr_pkg::vec_t                 rot       [3];

    // Unpack the input beat
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            vec[i]  = s_axis_tdata[i*VEC_W +: VEC_W];
            axis[i] = s_axis_tdata[AXIS_OFS + i*AXIS_W +: AXIS_W];
        end
        angle = s_axis_tdata[ANGLE_OFS +: avr_pkg::ANGLE_W];
    end

    // Load a stage when it is empty or its contents move on
    always_comb
    begin
        ld[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_axis_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            ld[k] = !valid_reg[k] || ld[k+1];
        end
        valid_next[0] = ld[0] ? s_axis_tvalid : valid_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            valid_next[k] = ld[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctl.ld1 = ld[0];
    assign ctl.ld2 = ld[1];
    assign ctl.ld3 = ld[2];
    assign ctl.ld4 = ld[3];
    assign ctl.ld5 = ld[4];
    assign ctl.ld6 = ld[5];

    assign s_axis_tready = ld[0];
    assign m_axis_tvalid = valid_reg[NUM_STAGES-1];

    // Sine and cosine, stages 1 and 2
    avr_trig u_trig (
        .clk   (clk),
        .ctl   (ctl),
        .angle (angle),
        .sn    (sn),
        .cs    (cs),
        .omc   (omc)
    );

    // Cross and dot products, stages 1 and 2
    avr_front u_front (
        .clk      (clk),
        .ctl      (ctl),
        .vec      (vec),
        .axis     (axis),
        .vec_out  (vec_s2),
        .axis_out (axis_s2),
        .cr       (cr),
        .dot      (dot)
    );

    // One lane per output component, stages 3 to 6
    for (genvar g = 0; g < 3; g++)
    begin : g_lane
        avr_lane u_lane (
            .clk  (clk),
            .ctl  (ctl),
            .vec  (vec_s2[g]),
            .axis (axis_s2[g]),
            .cr   (cr[g]),
            .dot  (dot),
            .sn   (sn),
            .cs   (cs),
            .omc  (omc),
            .rot  (rot[g])
        );
    end

    // Pack the output beat
    assign m_axis_tdata = avr_pkg::OUT_TDATA_W'({rot[2], rot[1], rot[0]});

endmodule
